/* rtl/core/fcst_pkg.sv */
package fcst_pkg;

  localparam int unsigned DEFAULT_CAPACITY   = 128;
  localparam int unsigned DEFAULT_ITEM_WIDTH = 32;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_ERASE    = 2'd1,
    REQ_CONTAINS = 2'd2,
    REQ_READ     = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FETCH,
    ST_RESP
  } state_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [31:0] item_value;
    logic [6:0]  position;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [7:0]  item_count;
    logic        is_empty;
  } rsp_t;

endpackage

/* rtl/core/fcst_mem.sv */
module fcst_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/fixed_capacity_set_table.sv */
// Set of distinct values packed in a single-port-read, single-port-write RAM; one item in flight.
// Insert and contains scan the entries until a hit or the last held entry; on a miss, insert
// appends the value when there is room. Erase scans to the hit, then shifts every entry behind it
// down one place. Read by position fetches the entry from the RAM, or answers at once when the
// position is out of range. A result waits in an output register.
// Reset (sync, active high) clears count and handshake state; RAM contents are not cleared.
module fixed_capacity_set_table #(
  parameter int unsigned CAPACITY   = fcst_pkg::DEFAULT_CAPACITY,
  parameter int unsigned ITEM_WIDTH = fcst_pkg::DEFAULT_ITEM_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fcst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fcst_pkg::rsp_t rsp
);

  import fcst_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 8;

  state_t                state, state_next;
  req_kind_t             kind;
  logic [ITEM_WIDTH-1:0] val;
  logic [AW-1:0]         idx, idx_next;
  logic [CW-1:0]         count, count_next;
  logic                  res_ok, res_ok_next;
  logic [31:0]           res_rd, res_rd_next;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_wdata, mem_rdata;

  logic hit, scan_last, shift_more, pos_ok, rsp_load;

  assign hit        = (mem_rdata == val);
  assign scan_last  = (XW'(idx) + XW'(1)) >= XW'(count);
  assign shift_more = (XW'(idx) + XW'(2)) < XW'(count);
  assign pos_ok     = XW'(req.position) < XW'(count);
  assign req_ready  = (state == ST_IDLE);
  assign rsp_load   = (state == ST_RESP) && (!rsp_valid || rsp_ready);

  fcst_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(ITEM_WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_READ) begin
            state_next = pos_ok ? ST_FETCH : ST_RESP;
          end else begin
            state_next = (count == '0) ? ST_RESP : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (kind == REQ_ERASE && !scan_last) ? ST_SHIFT : ST_RESP;
        end else if (scan_last) begin
          state_next = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (!shift_more) begin
          state_next = ST_RESP;
        end
      end
      ST_FETCH: state_next = ST_RESP;
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = val;
    mem_re      = 1'b0;
    mem_raddr   = AW'(XW'(idx) + XW'(1));
    idx_next    = idx;
    count_next  = count;
    res_ok_next = res_ok;
    res_rd_next = res_rd;
    case (state)
      ST_IDLE: begin
        idx_next    = '0;
        res_ok_next = 1'b0;
        res_rd_next = '0;
        mem_raddr   = (req.req_type == REQ_READ) ? AW'(req.position) : '0;
        if (req_valid) begin
          mem_re = (req.req_type == REQ_READ) ? pos_ok : (count != '0);
          // empty set: insert lands in entry zero right away
          if (req.req_type == REQ_INSERT && count == '0) begin
            mem_we      = 1'b1;
            mem_waddr   = '0;
            mem_wdata   = ITEM_WIDTH'(req.item_value);
            count_next  = CW'(1);
            res_ok_next = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          case (kind)
            REQ_ERASE: begin
              if (scan_last) begin
                count_next  = count - CW'(1);
                res_ok_next = 1'b1;
              end else begin
                mem_re = 1'b1;
              end
            end
            REQ_CONTAINS: res_ok_next = 1'b1;
            default:      res_ok_next = 1'b0;
          endcase
        end else if (scan_last) begin
          if (kind == REQ_INSERT && XW'(count) < XW'(CAPACITY)) begin
            mem_we      = 1'b1;
            mem_waddr   = AW'(count);
            count_next  = count + CW'(1);
            res_ok_next = 1'b1;
          end
        end else begin
          mem_re   = 1'b1;
          idx_next = AW'(XW'(idx) + XW'(1));
        end
      end
      ST_SHIFT: begin
        // entry idx+1 is on the read port; move it down and fetch idx+2
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        mem_raddr = AW'(XW'(idx) + XW'(2));
        if (shift_more) begin
          mem_re   = 1'b1;
          idx_next = AW'(XW'(idx) + XW'(1));
        end else begin
          count_next  = count - CW'(1);
          res_ok_next = 1'b1;
        end
      end
      ST_FETCH: begin
        res_ok_next = 1'b1;
        res_rd_next = 32'(mem_rdata);
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    res_ok <= res_ok_next;
    res_rd <= res_rd_next;
    if (state == ST_IDLE && req_valid) begin
      kind <= req.req_type;
      val  <= ITEM_WIDTH'(req.item_value);
    end
    if (rsp_load) begin
      rsp.ok         <= res_ok;
      rsp.read_value <= res_rd;
      rsp.item_count <= 8'(count);
      rsp.is_empty   <= (count == '0);
    end
  end

endmodule

/* sim/tb_fixed_capacity_set_table.sv */
module tb_fixed_capacity_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  import fcst_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int N_ITEMS = 1600;
  localparam int MAX_PRINTED = 100;

  typedef enum {MIX_LOAD, GROW_LOAD, SHRINK_LOAD} load_t;
  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_RARE_STALL} rdy_mode_t;

  // Shadow copy of the set: predicts each response and checks the DUT against it.
  class set_shadow;
    logic [31:0] slots [CAP];
    int unsigned n_held;
    rsp_t        predicted [$];
    int unsigned errors;
    int unsigned rsp_seen;

    function new();
      n_held = 0;
      errors = 0;
      rsp_seen = 0;
    endfunction

    function int find_slot(logic [31:0] v);
      for (int k = 0; k < int'(n_held); k++) begin
        if (slots[k] == v) return k;
      end
      return -1;
    endfunction

    function logic [31:0] pick_held();
      return slots[$urandom_range(0, n_held - 1)];
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int   at;
      want = '0;
      case (r.req_type)
        REQ_INSERT: begin
          if (n_held < CAP && find_slot(r.item_value) < 0) begin
            slots[n_held] = r.item_value;
            n_held++;
            want.ok = 1'b1;
          end
        end
        REQ_ERASE: begin
          at = find_slot(r.item_value);
          if (at >= 0) begin
            // close the gap left by the erased entry
            for (int k = at; k + 1 < int'(n_held); k++) slots[k] = slots[k + 1];
            n_held--;
            want.ok = 1'b1;
          end
        end
        REQ_CONTAINS: begin
          want.ok = (find_slot(r.item_value) >= 0);
        end
        REQ_READ: begin
          if (r.position < n_held) begin
            want.ok = 1'b1;
            want.read_value = slots[r.position];
          end
        end
      endcase
      want.item_count = 8'(n_held);
      want.is_empty = (n_held == 0);
      predicted.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t: response %0d: %s", $time, rsp_seen, what);
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      rsp_seen++;
      if (predicted.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      want = predicted.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok: got %b, want %b", got.ok, want.ok));
      if (got.read_value !== want.read_value)
        report($sformatf("read_value: got %h, want %h", got.read_value, want.read_value));
      if (got.item_count !== want.item_count)
        report($sformatf("item_count: got %0d, want %0d", got.item_count, want.item_count));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty: got %b, want %b", got.is_empty, want.is_empty));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  set_shadow   shadow;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  rdy_mode_t   ready_mode = RDY_ALWAYS;
  int unsigned mode_left = 0;

  fixed_capacity_set_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: ready pattern switches between random modes
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = rdy_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(30, 400);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS:  rsp_ready <= 1'b1;
      RDY_HALF:    rsp_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:  rsp_ready <= ($urandom_range(0, 4) == 0);
      default:     rsp_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) shadow.check_response(rsp);
  end

  task send_item(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    shadow.note_request(r);
    sent++;
  endtask

  task put(req_kind_t kind, logic [31:0] v, logic [6:0] pos);
    req_t r;
    r.req_type = kind;
    r.item_value = v;
    r.position = pos;
    send_item(r);
  endtask

  // hold off the sender until every response is back
  task drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (shadow.predicted.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function req_t make_req(load_t load);
    req_t r;
    int   roll;
    int   hit;
    roll = $urandom_range(0, 99);
    r.item_value = $urandom;
    r.position = 7'($urandom);
    case (load)
      GROW_LOAD: begin
        if (roll < 80) r.req_type = REQ_INSERT;
        else if (roll < 90) r.req_type = REQ_CONTAINS;
        else r.req_type = REQ_READ;
      end
      SHRINK_LOAD: begin
        if (roll < 70) r.req_type = REQ_ERASE;
        else if (roll < 85) r.req_type = REQ_CONTAINS;
        else r.req_type = REQ_READ;
      end
      default: begin
        if (roll < 35) r.req_type = REQ_INSERT;
        else if (roll < 65) r.req_type = REQ_ERASE;
        else if (roll < 80) r.req_type = REQ_CONTAINS;
        else r.req_type = REQ_READ;
      end
    endcase
    // inserts mostly bring fresh values; lookups mostly hit
    hit = (r.req_type == REQ_INSERT) ? 25 : 70;
    if ($urandom_range(0, 31) == 0)
      r.item_value = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    else if (shadow.n_held > 0 && $urandom_range(0, 99) < hit)
      r.item_value = shadow.pick_held();
    // half the reads land near the current count
    if (r.req_type == REQ_READ && $urandom_range(0, 1) == 1) begin
      r.position = 7'($urandom_range(0, shadow.n_held));
      if (shadow.n_held >= CAP) r.position = 7'($urandom_range(CAP - 2, CAP - 1));
    end
    return r;
  endfunction

  initial begin
    int    extra;
    load_t load;
    shadow = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty set corner cases
    put(REQ_READ, 32'h0, 7'd0);
    put(REQ_READ, 32'hFFFF_FFFF, 7'd127);
    put(REQ_CONTAINS, 32'h0, 7'd0);
    put(REQ_ERASE, 32'h0, 7'd0);
    put(REQ_INSERT, 32'h0, 7'd0);
    put(REQ_INSERT, 32'hFFFF_FFFF, 7'd127);
    put(REQ_INSERT, 32'h0, 7'd0);              // duplicate, refused
    put(REQ_INSERT, 32'hA5A5_A5A5, 7'd0);
    put(REQ_CONTAINS, 32'hFFFF_FFFF, 7'd0);
    put(REQ_CONTAINS, 32'h1234_5678, 7'd0);
    put(REQ_READ, 32'h0, 7'd0);
    put(REQ_READ, 32'h0, 7'd2);                // last held entry
    put(REQ_READ, 32'h0, 7'd3);                // position equal to count
    put(REQ_READ, 32'h0, 7'd127);
    put(REQ_ERASE, 32'h0, 7'd0);               // first entry, shift down
    put(REQ_READ, 32'h0, 7'd0);
    put(REQ_READ, 32'h0, 7'd1);
    put(REQ_ERASE, 32'hA5A5_A5A5, 7'd0);       // last entry, no shift
    put(REQ_ERASE, 32'hA5A5_A5A5, 7'd0);       // already gone
    put(REQ_ERASE, 32'hFFFF_FFFF, 7'd0);       // back to empty
    put(REQ_CONTAINS, 32'hFFFF_FFFF, 7'd0);
    drain();

    load = MIX_LOAD;
    while (sent < N_ITEMS) begin
      extra = 0;
      case (load)
        GROW_LOAD: begin
          // run past full so inserts get refused for lack of room
          while (extra < 20) begin
            send_item(make_req(GROW_LOAD));
            if (shadow.n_held == CAP) extra++;
          end
          load = SHRINK_LOAD;
        end
        SHRINK_LOAD: begin
          while (extra < 10) begin
            send_item(make_req(SHRINK_LOAD));
            if (shadow.n_held == 0) extra++;
          end
          load = MIX_LOAD;
        end
        default: begin
          repeat (150) send_item(make_req(MIX_LOAD));
          load = GROW_LOAD;
        end
      endcase
      drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("** fixed_capacity_set_table: PASSED **");
    end else begin
      $display("** fixed_capacity_set_table: FAILED **");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("** fixed_capacity_set_table: FAILED **");
    $finish;
  end

endmodule
